FILE: src/btc_pkg.sv
// shared types and constants for the beep and led tick controller
`timescale 1ns / 1ps
`default_nettype none

package btc_pkg;

    localparam int NUM_LEDS = 3;

    localparam int TICK_W  = 24;
    localparam int CFG_W   = 10;
    localparam int RING_W  = 8;
    localparam int LTIME_W = 24;
    localparam int IDX_W   = 3;

    // one dividend bit per step over the whole tick counter width
    localparam int DIV_STEPS = TICK_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [TICK_W-1:0]  TICK_WRAP   = TICK_W'(10000000);
    localparam logic [LTIME_W-1:0] MS_PER_TICK = LTIME_W'(10);

    typedef logic [NUM_LEDS-1:0] t_leds;

    typedef enum logic [IDX_W-1:0] {
        CFG_BEEP_PERIOD  = 3'd0,
        CFG_BEEP_ON      = 3'd1,
        CFG_LED_PERIOD   = 3'd2,
        CFG_LED_ON       = 3'd3,
        CFG_LED_INTERVAL = 3'd4,
        CFG_BLINK_MASK   = 3'd5
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: src/beep_and_led_tick_controller.sv
// Beeper and LED tick controller. Each input word is one 10 ms tick; ring and LED
// loads it carries are applied before the tick. The tick counter, the modulo values
// against the beep period, blink period and check interval, and the burst phase modulo
// the beep period are found by four restoring remainder lanes that take one dividend
// bit per cycle: a word is accepted, run through 24 remainder steps, then its new
// state is committed into the output word once that is free. The next word is
// accepted in the cycle after the commit while the result may still wait to be taken.
// The user must write configuration through the plain write port only while no tick
// is in progress; the block does not enforce it. A zero period or interval acts as one.
`timescale 1ns / 1ps
`default_nettype none

module beep_and_led_tick_controller
    import btc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_ring_load_valid,
    input  wire logic [RING_W-1:0]  i_ring_count,
    input  wire logic               i_led_load_valid,
    input  wire logic [LTIME_W-1:0] i_led_time_ms,
    input  wire t_leds              i_led_enable,
    input  wire logic               i_always_on,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_beep_level,
    output t_leds                   o_led_drive,
    output t_leds                   o_led_status_out,
    output logic [TICK_W-1:0]       o_ticks_now,
    output logic [RING_W-1:0]       o_rings_left,
    output logic [LTIME_W-1:0]      o_led_time_left
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    btc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    btc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_ring_load_valid (i_ring_load_valid),
        .i_ring_count      (i_ring_count),
        .i_led_load_valid  (i_led_load_valid),
        .i_led_time_ms     (i_led_time_ms),
        .i_led_enable      (i_led_enable),
        .i_always_on       (i_always_on),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_beep_level      (o_beep_level),
        .o_led_drive       (o_led_drive),
        .o_led_status_out  (o_led_status_out),
        .o_ticks_now       (o_ticks_now),
        .o_rings_left      (o_rings_left),
        .o_led_time_left   (o_led_time_left)
    );

endmodule

`default_nettype wire

FILE: src/btc_rem.sv
// restoring remainder lane, one dividend bit per step
`timescale 1ns / 1ps
`default_nettype none

module btc_rem
    import btc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_init,
    input  wire logic              i_step,
    input  wire logic [TICK_W-1:0] i_dividend,
    input  wire logic [CFG_W-1:0]  i_divisor,
    output logic      [CFG_W-1:0]  o_rem
);

    logic [TICK_W-1:0] r_dvd, n_dvd;
    logic [CFG_W-1:0]  r_rem, n_rem;
    logic [CFG_W:0]    w_trial;

    always_comb begin
        w_trial = {r_rem, r_dvd[TICK_W-1]};
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        if (i_init) begin
            n_dvd = i_dividend;
            n_rem = '0;
        end else if (i_step) begin
            n_dvd = {r_dvd[TICK_W-2:0], 1'b0};
            // partial remainder stays below the divisor, so it fits the divisor width
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = CFG_W'(w_trial - {1'b0, i_divisor});
            end else begin
                n_rem = w_trial[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

FILE: src/btc_ctrl.sv
// controller: word accept, remainder step count and commit
`timescale 1ns / 1ps
`default_nettype none

module btc_ctrl
    import btc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step_cnt, n_step_cnt;

    always_comb begin
        n_state    = r_state;
        n_step_cnt = r_step_cnt;
        o_ready    = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step_cnt = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_step_cnt = r_step_cnt + 1'b1;
                if (r_step_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_step_cnt = '0;
                    n_state    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step_cnt <= STEP_W'(DIV_STEPS - 1))
        else $error("step count out of range");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_step_cnt == STEP_W'(DIV_STEPS - 1)) |=> r_state == ST_DONE)
        else $error("remainder pass did not end");

    a_finish_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_cmd.finish && o_ready)
        else $error("commit not followed by idle");

endmodule

`default_nettype wire

FILE: src/btc_dp.sv
// datapath: config, tick state, remainder lanes, beeper and led logic, output word
`timescale 1ns / 1ps
`default_nettype none

module btc_dp
    import btc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_ring_load_valid,
    input  wire logic [RING_W-1:0]  i_ring_count,
    input  wire logic               i_led_load_valid,
    input  wire logic [LTIME_W-1:0] i_led_time_ms,
    input  wire t_leds              i_led_enable,
    input  wire logic               i_always_on,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_beep_level,
    output t_leds                   o_led_drive,
    output t_leds                   o_led_status_out,
    output logic [TICK_W-1:0]       o_ticks_now,
    output logic [RING_W-1:0]       o_rings_left,
    output logic [LTIME_W-1:0]      o_led_time_left
);

    // configuration
    logic [CFG_W-1:0] r_beep_period, r_beep_on, r_led_period, r_led_on, r_led_interval;
    t_leds            r_blink_mask;

    // tick state
    logic [TICK_W-1:0]  r_tick_count, n_tick_count;
    logic               r_burst_active, n_burst_active;
    logic [CFG_W-1:0]   r_burst_phase, n_burst_phase;
    logic [RING_W-1:0]  r_rings, n_rings;
    logic [LTIME_W-1:0] r_led_timeout, n_led_timeout;
    t_leds              r_led_status, n_led_status;
    logic               r_keep_on, n_keep_on;
    t_leds              r_led_pins, n_led_pins;

    // output word
    logic               r_out_valid, n_out_valid;
    logic               r_out_beep, n_out_beep;
    t_leds              r_out_drive, n_out_drive;
    t_leds              r_out_status, n_out_status;
    logic [TICK_W-1:0]  r_out_ticks, n_out_ticks;
    logic [RING_W-1:0]  r_out_rings, n_out_rings;
    logic [LTIME_W-1:0] r_out_time, n_out_time;

    logic [CFG_W-1:0]   w_bp, w_lp, w_ci;
    logic [TICK_W:0]    w_tick_inc;
    logic [TICK_W-1:0]  w_tick_next;
    logic [CFG_W-1:0]   w_mod_bp, w_mod_lp, w_mod_ci, w_mod_phase;
    logic [CFG_W-1:0]   w_phase_inc;
    logic               w_window;

    // zero periods behave as one
    assign w_bp = (r_beep_period  == '0) ? CFG_W'(1) : r_beep_period;
    assign w_lp = (r_led_period   == '0) ? CFG_W'(1) : r_led_period;
    assign w_ci = (r_led_interval == '0) ? CFG_W'(1) : r_led_interval;

    assign w_tick_inc  = {1'b0, r_tick_count} + (TICK_W+1)'(1);
    assign w_tick_next = (w_tick_inc > {1'b0, TICK_WRAP}) ? '0 : w_tick_inc[TICK_W-1:0];

    btc_rem u_rem_bp (
        .i_clk      (i_clk),
        .i_init     (i_cmd.load),
        .i_step     (i_cmd.step),
        .i_dividend (w_tick_next),
        .i_divisor  (w_bp),
        .o_rem      (w_mod_bp)
    );

    btc_rem u_rem_lp (
        .i_clk      (i_clk),
        .i_init     (i_cmd.load),
        .i_step     (i_cmd.step),
        .i_dividend (w_tick_next),
        .i_divisor  (w_lp),
        .o_rem      (w_mod_lp)
    );

    btc_rem u_rem_ci (
        .i_clk      (i_clk),
        .i_init     (i_cmd.load),
        .i_step     (i_cmd.step),
        .i_dividend (w_tick_next),
        .i_divisor  (w_ci),
        .o_rem      (w_mod_ci)
    );

    btc_rem u_rem_phase (
        .i_clk      (i_clk),
        .i_init     (i_cmd.load),
        .i_step     (i_cmd.step),
        .i_dividend ({(TICK_W-CFG_W)'(0), r_burst_phase}),
        .i_divisor  (w_bp),
        .o_rem      (w_mod_phase)
    );

    assign w_phase_inc = r_burst_phase + CFG_W'(1);
    assign w_window    = w_mod_lp < r_led_on;

    always_comb begin
        n_tick_count   = r_tick_count;
        n_burst_active = r_burst_active;
        n_burst_phase  = r_burst_phase;
        n_rings        = r_rings;
        n_led_timeout  = r_led_timeout;
        n_led_status   = r_led_status;
        n_keep_on      = r_keep_on;
        n_led_pins     = r_led_pins;
        n_out_valid    = r_out_valid;
        n_out_beep     = r_out_beep;
        n_out_drive    = r_out_drive;
        n_out_status   = r_out_status;
        n_out_ticks    = r_out_ticks;
        n_out_rings    = r_out_rings;
        n_out_time     = r_out_time;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            // software loads go in before the tick
            n_tick_count = w_tick_next;
            if (i_ring_load_valid) begin
                n_rings = i_ring_count;
            end
            if (i_led_load_valid) begin
                n_led_timeout = i_led_time_ms;
                n_led_status  = i_led_enable;
                n_keep_on     = i_always_on;
            end
        end

        if (i_cmd.finish) begin
            // beeper
            n_out_beep = r_burst_active && (w_mod_phase < r_beep_on);
            if (r_burst_active && (w_phase_inc < w_bp)) begin
                n_burst_phase = w_phase_inc;
            end else begin
                n_burst_active = 1'b0;
                n_burst_phase  = '0;
            end
            if (w_mod_bp == '0 && r_rings != '0) begin
                n_rings        = r_rings - RING_W'(1);
                n_burst_phase  = '0;
                n_burst_active = 1'b1;
            end

            // leds
            if (w_mod_ci == '0) begin
                n_led_pins = r_led_pins | (r_led_status & (~r_blink_mask | {NUM_LEDS{w_window}}));
            end else if (w_mod_ci == (w_ci >> 1) && !r_keep_on) begin
                n_led_pins = '0;
            end

            // timeout, expiry drops status and keep-on
            if (r_led_timeout < MS_PER_TICK) begin
                n_led_timeout = '0;
                n_led_status  = '0;
                n_keep_on     = 1'b0;
            end else begin
                n_led_timeout = r_led_timeout - MS_PER_TICK;
                if (r_led_timeout == MS_PER_TICK) begin
                    n_led_status = '0;
                    n_keep_on    = 1'b0;
                end
            end

            n_out_drive  = n_led_pins;
            n_out_status = n_led_status;
            n_out_ticks  = r_tick_count;
            n_out_rings  = n_rings;
            n_out_time   = n_led_timeout;
            n_out_valid  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_period  <= CFG_W'(10);
            r_beep_on      <= CFG_W'(5);
            r_led_period   <= CFG_W'(20);
            r_led_on       <= CFG_W'(10);
            r_led_interval <= CFG_W'(100);
            r_blink_mask   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BEEP_PERIOD:  r_beep_period  <= i_cfg_data;
                CFG_BEEP_ON:      r_beep_on      <= i_cfg_data;
                CFG_LED_PERIOD:   r_led_period   <= i_cfg_data;
                CFG_LED_ON:       r_led_on       <= i_cfg_data;
                CFG_LED_INTERVAL: r_led_interval <= i_cfg_data;
                CFG_BLINK_MASK:   r_blink_mask   <= i_cfg_data[NUM_LEDS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count   <= '0;
            r_burst_active <= 1'b0;
            r_burst_phase  <= '0;
            r_rings        <= '0;
            r_led_timeout  <= '0;
            r_led_status   <= '0;
            r_keep_on      <= 1'b0;
            r_led_pins     <= '0;
            r_out_valid    <= 1'b0;
            r_out_beep     <= 1'b0;
            r_out_drive    <= '0;
            r_out_status   <= '0;
            r_out_ticks    <= '0;
            r_out_rings    <= '0;
            r_out_time     <= '0;
        end else begin
            r_tick_count   <= n_tick_count;
            r_burst_active <= n_burst_active;
            r_burst_phase  <= n_burst_phase;
            r_rings        <= n_rings;
            r_led_timeout  <= n_led_timeout;
            r_led_status   <= n_led_status;
            r_keep_on      <= n_keep_on;
            r_led_pins     <= n_led_pins;
            r_out_valid    <= n_out_valid;
            r_out_beep     <= n_out_beep;
            r_out_drive    <= n_out_drive;
            r_out_status   <= n_out_status;
            r_out_ticks    <= n_out_ticks;
            r_out_rings    <= n_out_rings;
            r_out_time     <= n_out_time;
        end
    end

    // output word has its own registers so the next word's loads leave it alone
    assign o_stat.out_free  = !r_out_valid || i_ready;
    assign o_valid          = r_out_valid;
    assign o_beep_level     = r_out_beep;
    assign o_led_drive      = r_out_drive;
    assign o_led_status_out = r_out_status;
    assign o_ticks_now      = r_out_ticks;
    assign o_rings_left     = r_out_rings;
    assign o_led_time_left  = r_out_time;

    a_tick_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick_count <= TICK_WRAP)
        else $error("tick counter past wrap");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_burst_active |-> r_burst_phase == '0)
        else $error("phase left over outside a burst");

    a_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && n_led_timeout == '0) |=> (r_led_status == '0 && !r_keep_on))
        else $error("expired timeout left led status set");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !i_cmd.finish)
        else $error("commit over an untaken word");

endmodule

`default_nettype wire

FILE: tb/sv/tb_beep_and_led_tick_controller.sv
// self-checking testbench for the beep and led tick controller
`timescale 1ns / 1ps

module tb_beep_and_led_tick_controller
    import btc_pkg::*;
();

    typedef struct packed {
        logic               ring_load;
        logic [RING_W-1:0]  ring_count;
        logic               led_load;
        logic [LTIME_W-1:0] led_time_ms;
        t_leds              led_enable;
        logic               always_on;
    } t_tick_word;

    typedef struct packed {
        logic               beep;
        t_leds              drive;
        t_leds              status;
        logic [TICK_W-1:0]  ticks;
        logic [RING_W-1:0]  rings;
        logic [LTIME_W-1:0] time_left;
    } t_tick_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_ring_load_valid = 1'b0;
    logic [RING_W-1:0]  i_ring_count = '0;
    logic               i_led_load_valid = 1'b0;
    logic [LTIME_W-1:0] i_led_time_ms = '0;
    t_leds              i_led_enable = '0;
    logic               i_always_on = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_beep_level;
    t_leds              o_led_drive;
    t_leds              o_led_status_out;
    logic [TICK_W-1:0]  o_ticks_now;
    logic [RING_W-1:0]  o_rings_left;
    logic [LTIME_W-1:0] o_led_time_left;

    beep_and_led_tick_controller i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_ring_load_valid(i_ring_load_valid),
        .i_ring_count     (i_ring_count),
        .i_led_load_valid (i_led_load_valid),
        .i_led_time_ms    (i_led_time_ms),
        .i_led_enable     (i_led_enable),
        .i_always_on      (i_always_on),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_beep_level     (o_beep_level),
        .o_led_drive      (o_led_drive),
        .o_led_status_out (o_led_status_out),
        .o_ticks_now      (o_ticks_now),
        .o_rings_left     (o_rings_left),
        .o_led_time_left  (o_led_time_left)
    );

    always #2 i_clk = ~i_clk;

    // register shadow, reset values
    logic [CFG_W-1:0] cfg_beep_period = 10'd10;
    logic [CFG_W-1:0] cfg_beep_on     = 10'd5;
    logic [CFG_W-1:0] cfg_led_period  = 10'd20;
    logic [CFG_W-1:0] cfg_led_on      = 10'd10;
    logic [CFG_W-1:0] cfg_interval    = 10'd100;
    t_leds            cfg_blink       = '0;

    // controller state as the testbench sees it
    logic [TICK_W-1:0]  tick_cnt  = '0;
    logic               burst_on  = 1'b0;
    logic [CFG_W-1:0]   burst_ph  = '0;
    logic [RING_W-1:0]  rings_q   = '0;
    logic [LTIME_W-1:0] led_tmo   = '0;
    t_leds              led_stat  = '0;
    logic               keep_lit  = 1'b0;
    t_leds              pins      = '0;

    t_tick_report tick_reports_due[$];
    int mismatch_cnt     = 0;
    int ticks_sent       = 0;
    int reports_checked  = 0;
    int settings_applied = 0;
    int tx_idle_pct      = 7;
    int rx_idle_pct      = 7;
    int rx_hold_req      = 0;
    int rx_hold_left     = 0;

    function automatic t_tick_report advance_tick(input t_tick_word w);
        t_tick_report r;
        int unsigned  bp;
        int unsigned  lp;
        int unsigned  ci;
        logic         beep;
        logic         window;
        int           i;
        bp = (cfg_beep_period == 0) ? 1 : cfg_beep_period;
        lp = (cfg_led_period == 0) ? 1 : cfg_led_period;
        ci = (cfg_interval == 0) ? 1 : cfg_interval;
        beep = 1'b0;
        if (w.ring_load) rings_q = w.ring_count;
        if (w.led_load) begin
            led_tmo  = w.led_time_ms;
            led_stat = w.led_enable;
            keep_lit = w.always_on;
        end
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt > TICK_WRAP) tick_cnt = '0;

        if (burst_on) begin
            beep = ((burst_ph % bp) < cfg_beep_on);
            burst_ph = burst_ph + 1'b1;
            // a shrunk period ends the burst early
            if (burst_ph >= bp) begin
                burst_on = 1'b0;
                burst_ph = '0;
            end
        end else begin
            burst_ph = '0;
        end
        if ((tick_cnt % bp) == 0 && rings_q != 0) begin
            rings_q  = rings_q - 1'b1;
            burst_ph = '0;
            burst_on = 1'b1;
        end

        if ((tick_cnt % ci) == 0) begin
            window = ((tick_cnt % lp) < cfg_led_on);
            for (i = 0; i < NUM_LEDS; i++) begin
                if (led_stat[i] && (!cfg_blink[i] || window)) pins[i] = 1'b1;
            end
        end else if ((tick_cnt % ci) == ci / 2 && !keep_lit) begin
            pins = '0;
        end

        if (led_tmo != 0) led_tmo = (led_tmo < MS_PER_TICK) ? '0 : led_tmo - MS_PER_TICK;
        if (led_tmo == 0) begin
            led_stat = '0;
            keep_lit = 1'b0;
        end

        r.beep      = beep;
        r.drive     = pins;
        r.status    = led_stat;
        r.ticks     = tick_cnt;
        r.rings     = rings_q;
        r.time_left = led_tmo;
        return r;
    endfunction

    function automatic t_tick_word mk_tick(input logic rl, input logic [RING_W-1:0] rc,
                                           input logic ll, input logic [LTIME_W-1:0] tm,
                                           input t_leds en, input logic ao);
        return '{rl, rc, ll, tm, en, ao};
    endfunction

    // random payload with both loads off, the block must ignore it
    function automatic t_tick_word quiet_tick();
        return mk_tick(1'b0, RING_W'($urandom_range(255)), 1'b0,
                       LTIME_W'($urandom_range(16777215)),
                       NUM_LEDS'($urandom_range(7)), 1'($urandom_range(1)));
    endfunction

    function automatic t_tick_word random_tick();
        t_tick_word w;
        w.ring_load  = ($urandom_range(99) < 12);
        w.ring_count = ($urandom_range(9) == 0) ? RING_W'($urandom_range(255))
                                                : RING_W'($urandom_range(4));
        w.led_load   = ($urandom_range(99) < 15);
        case ($urandom_range(9))
            0: w.led_time_ms = LTIME_W'($urandom_range(16777215));
            1: w.led_time_ms = LTIME_W'($urandom_range(9));
            default: w.led_time_ms = LTIME_W'($urandom_range(1500));
        endcase
        w.led_enable = NUM_LEDS'($urandom_range(7));
        w.always_on  = 1'($urandom_range(1));
        return w;
    endfunction

    // send_tick lowers valid only for a gap, so back-to-back words keep it high
    task automatic send_tick(input t_tick_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_ring_load_valid <= w.ring_load;
        i_ring_count      <= w.ring_count;
        i_led_load_valid  <= w.led_load;
        i_led_time_ms     <= w.led_time_ms;
        i_led_enable      <= w.led_enable;
        i_always_on       <= w.always_on;
        do @(posedge i_clk); while (!o_ready);
        tick_reports_due.push_back(advance_tick(w));
        ticks_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tick_reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_BEEP_PERIOD:  cfg_beep_period = val;
            CFG_BEEP_ON:      cfg_beep_on     = val;
            CFG_LED_PERIOD:   cfg_led_period  = val;
            CFG_LED_ON:       cfg_led_on      = val;
            CFG_LED_INTERVAL: cfg_interval    = val;
            CFG_BLINK_MASK:   cfg_blink       = val[NUM_LEDS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] bp, input logic [CFG_W-1:0] bon,
                                  input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] lon,
                                  input logic [CFG_W-1:0] ci, input t_leds mask);
        write_reg(CFG_BEEP_PERIOD, bp);
        write_reg(CFG_BEEP_ON, bon);
        write_reg(CFG_LED_PERIOD, lp);
        write_reg(CFG_LED_ON, lon);
        write_reg(CFG_LED_INTERVAL, ci);
        write_reg(CFG_BLINK_MASK, CFG_W'(mask));
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // receiver: random stalls plus an occasional long hold
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_tick_report got;
        t_tick_report exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_beep_level, o_led_drive, o_led_status_out, o_ticks_now,
                    o_rings_left, o_led_time_left};
            if (tick_reports_due.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, got ticks_now %0d",
                         $time, got.ticks);
                mismatch_cnt++;
            end else begin
                exp_r = tick_reports_due.pop_front();
                check_field("beep_level", exp_r.beep, got.beep);
                check_field("led_drive", exp_r.drive, got.drive);
                check_field("led_status_out", exp_r.status, got.status);
                check_field("ticks_now", exp_r.ticks, got.ticks);
                check_field("rings_left", exp_r.rings, got.rings);
                check_field("led_time_left", exp_r.time_left, got.time_left);
                reports_checked++;
            end
        end
    end

    task automatic test_reset_defaults();
        send_tick(mk_tick(1'b1, 8'd3, 1'b1, 24'd35, 3'd7, 1'b0));
        send_tick(quiet_tick());
        send_tick(quiet_tick());
        wait_idle();
    endtask

    // zero periods act as one, beep on past the period, led timeout edges
    task automatic test_load_extremes();
        apply_settings(10'd0, 10'd1023, 10'd0, 10'd0, 10'd0, 3'd7);
        send_tick(mk_tick(1'b1, 8'd255, 1'b1, 24'hFFFFFF, 3'd7, 1'b1));
        send_tick(mk_tick(1'b0, 8'hFF, 1'b0, 24'hFFFFFF, 3'd7, 1'b1));
        send_tick(mk_tick(1'b0, 8'd0, 1'b1, 24'd0, 3'd7, 1'b1));
        send_tick(mk_tick(1'b0, 8'd0, 1'b1, 24'd5, 3'd3, 1'b0));
        send_tick(mk_tick(1'b0, 8'd0, 1'b1, 24'd10, 3'd4, 1'b0));
        send_tick(mk_tick(1'b1, 8'd0, 1'b0, 24'd0, 3'd0, 1'b0));
        wait_idle();
    endtask

    // short interval so both the on check and the half-way off are hit
    task automatic test_interval_halves();
        apply_settings(10'd3, 10'd1, 10'd4, 10'd2, 10'd2, 3'd5);
        send_tick(mk_tick(1'b1, 8'd2, 1'b1, 24'd100, 3'd7, 1'b0));
        send_tick(quiet_tick());
        send_tick(mk_tick(1'b0, 8'd0, 1'b1, 24'd60, 3'd6, 1'b1));
        send_tick(quiet_tick());
        send_tick(quiet_tick());
        wait_idle();
    endtask

    task automatic test_period_change_mid_burst();
        int guard;
        apply_settings(10'd6, 10'd6, 10'd1000, 10'd1000, 10'd1000, 3'd0);
        send_tick(mk_tick(1'b1, 8'd2, 1'b0, 24'd0, 3'd0, 1'b0));
        guard = 0;
        while (!(burst_on && burst_ph >= 3) && guard < 10) begin
            send_tick(quiet_tick());
            guard++;
        end
        wait_idle();
        // phase now sits past the new period
        apply_settings(10'd2, 10'd6, 10'd1000, 10'd1000, 10'd1000, 3'd0);
        send_tick(quiet_tick());
        send_tick(quiet_tick());
        wait_idle();
    endtask

    task automatic test_random_settings();
        int ph;
        logic [CFG_W-1:0] bp, bon, lp, lon, ci;
        t_leds mask;
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                bp = 10'd1; bon = 10'd0; lp = 10'd1; lon = 10'd0; ci = 10'd2; mask = 3'd0;
            end else if (ph == 1) begin
                bp = 10'd1000; bon = 10'd1000; lp = 10'd1000; lon = 10'd1000;
                ci = 10'd1000; mask = 3'd7;
            end else begin
                bp   = ($urandom_range(9) == 0) ? 10'd0 : CFG_W'($urandom_range(1, 12));
                bon  = ($urandom_range(19) == 0) ? 10'd1000 : CFG_W'($urandom_range(bp + 2));
                lp   = ($urandom_range(9) == 0) ? 10'd0 : CFG_W'($urandom_range(1, 16));
                lon  = CFG_W'($urandom_range(lp + 1));
                case ($urandom_range(9))
                    0: ci = 10'd0;
                    1: ci = 10'd1;
                    default: ci = CFG_W'($urandom_range(2, 30));
                endcase
                mask = NUM_LEDS'($urandom_range(7));
            end
            tx_idle_pct = (ph == 4) ? 0 : 7;
            rx_idle_pct = (ph == 4) ? 0 : 7;
            apply_settings(bp, bon, lp, lon, ci, mask);
            repeat (95) send_tick(random_tick());
            wait_idle();
        end
        tx_idle_pct = 7;
        rx_idle_pct = 7;
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_hold_req = 300;
        repeat (12) send_tick(random_tick());
        wait_idle();
        tx_idle_pct = 7;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_load_extremes();
        test_interval_halves();
        test_period_change_mid_burst();
        test_random_settings();
        test_output_backpressure();
        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("run covered %0d ticks over %0d register settings, %0d words checked",
                 ticks_sent, settings_applied, reports_checked);
        $display("mismatches seen: %0d", mismatch_cnt);
        if (mismatch_cnt == 0 && tick_reports_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d words outstanding", tick_reports_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
